### hdl/dda_pkg.sv
// Shared types and constants for the DDA line rasterizer.
package dda_pkg;

    // Width of the rows and cols registers
    localparam int DIM_BITS = 12;

    // Configuration register indexes
    localparam int          CFG_IDX_BITS = 1;
    localparam logic [0:0]  REG_ROWS     = 1'b0;
    localparam logic [0:0]  REG_COLS     = 1'b1;

    // Register reset values
    localparam logic [DIM_BITS-1:0] ROWS_RESET = 12'd480;
    localparam logic [DIM_BITS-1:0] COLS_RESET = 12'd640;

    // Input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_line;   // start transaction accepted
        logic advance;     // step transaction accepted
        logic emit;        // load the output register
        logic div_run;     // run one divider iteration
    } ctrl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_last;    // divider on its final iteration
    } status_t;

endpackage

### hdl/dda_ctrl.sv
// Controller state machine: handshakes and divider sequencing.
module dda_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    output logic              out_valid,
    input  logic              out_stall,
    input  dda_pkg::status_t  status,
    output dda_pkg::ctrl_t    ctrl
);

    dda_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;

    // Take a transaction when idle and the output register is free or draining
    assign in_stall = (state_reg != dda_pkg::S_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // Commands
    always_comb
    begin
        ctrl.load_line = accept && (action == dda_pkg::ACT_START);
        ctrl.advance   = accept && (action == dda_pkg::ACT_STEP);
        ctrl.emit      = accept;
        ctrl.div_run   = (state_reg == dda_pkg::S_DIV);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dda_pkg::S_IDLE:
            begin
                if (ctrl.load_line)
                begin
                    state_next = dda_pkg::S_DIV;
                end
            end
            dda_pkg::S_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = dda_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dda_pkg::S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared once taken
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dda_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/dda_datapath.sv
// Datapath: line state, restoring divider, position update, clipping, output register.
module dda_datapath #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dda_pkg::ctrl_t                       ctrl,
    output dda_pkg::status_t                     status,
    input  logic                                 cfg_we,
    input  logic [dda_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [dda_pkg::DIM_BITS-1:0]         cfg_data,
    input  logic signed [COORD_BITS-1:0]         start_x,
    input  logic signed [COORD_BITS-1:0]         start_y,
    input  logic signed [COORD_BITS-1:0]         end_x,
    input  logic signed [COORD_BITS-1:0]         end_y,
    input  logic [7:0]                           pixel_value,
    output logic signed [COORD_BITS-1:0]         pix_x,
    output logic signed [COORD_BITS-1:0]         pix_y,
    output logic [7:0]                           pix_out_value,
    output logic                                 write_enable,
    output logic                                 last,
    output logic                                 idle
);

    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int P    = C + F;                 // position width
    localparam int CNT_BITS = $clog2(F + 1);
    localparam int W    = (C - 1 > dda_pkg::DIM_BITS) ? C - 1 : dda_pkg::DIM_BITS;
    localparam logic [P-1:0]        ONE   = P'(1) << F;
    localparam logic [P:0]          HALF  = (P + 1)'(1) << (F - 1);
    localparam logic [CNT_BITS-1:0] CNT_TOP = CNT_BITS'(F);

    // Configuration
    logic [dda_pkg::DIM_BITS-1:0] rows_reg, cols_reg;

    // Line state
    logic                 active_reg;
    logic signed [P-1:0]  pos_x_reg, pos_y_reg;
    logic [C-1:0]         target_x_reg, target_y_reg;
    logic [C-1:0]         steps_left_reg;
    logic [7:0]           line_value_reg;
    logic                 x_major_reg, x_neg_reg, y_neg_reg;

    // Divider
    logic [C:0]           rem_reg;
    logic [F:0]           quo_reg;
    logic [CNT_BITS-1:0]  cnt_reg;

    // Output register
    logic [C-1:0]         pix_x_reg, pix_y_reg;
    logic [7:0]           value_reg;
    logic                 we_reg, last_reg, idle_reg;

    // Start decode
    logic signed [C:0]    dx, dy;
    logic [C:0]           dx_abs, dy_abs;
    logic [C-1:0]         ax, ay, major, minor;
    logic                 st_x_major, st_active;

    // Step
    logic [P-1:0]         quo_ext, x_inc, y_inc, step_x, step_y;
    logic signed [P-1:0]  pos_x_next, pos_y_next;
    logic [C-1:0]         steps_dec;
    logic [C-1:0]         px_step, py_step;

    // Divider iteration
    logic                 div_ge;
    logic [C:0]           rem_sub;

    // Output selection
    logic [C-1:0]         o_x, o_y;
    logic [7:0]           o_val;
    logic                 o_valid, o_last, o_idle;

    // Round a position to a pixel: trunc(pos + 0.5) toward zero
    function automatic logic [C-1:0] to_pixel(input logic [P-1:0] pos);
        logic [P:0] t;
        logic [C:0] fl;
        t  = {pos[P-1], pos} + HALF;
        fl = t[P:F];
        if (t[P] && (t[F-1:0] != '0))
        begin
            fl = fl + 1'b1;
        end
        return fl[C-1:0];
    endfunction

    // Pixel inside the image
    function automatic logic in_image(input logic [C-1:0] x, input logic [C-1:0] y,
                                      input logic [dda_pkg::DIM_BITS-1:0] nr,
                                      input logic [dda_pkg::DIM_BITS-1:0] nc);
        logic xin, yin;
        xin = !x[C-1] && (W'(x[C-2:0]) < W'(nc));
        yin = !y[C-1] && (W'(y[C-2:0]) < W'(nr));
        return xin && yin;
    endfunction

    // Deltas and axis choice for a start transaction
    always_comb
    begin
        dx         = {end_x[C-1], end_x} - {start_x[C-1], start_x};
        dy         = {end_y[C-1], end_y} - {start_y[C-1], start_y};
        dx_abs     = dx[C] ? -dx : dx;
        dy_abs     = dy[C] ? -dy : dy;
        ax         = dx_abs[C-1:0];
        ay         = dy_abs[C-1:0];
        st_x_major = ax > ay;
        major      = st_x_major ? ax : ay;
        minor      = st_x_major ? ay : ax;
        st_active  = (major != '0);
    end

    // Per-step increments: +-1 on the major axis, +-quotient on the minor
    always_comb
    begin
        quo_ext    = P'(quo_reg);
        x_inc      = x_major_reg ? ONE : quo_ext;
        y_inc      = x_major_reg ? quo_ext : ONE;
        step_x     = x_neg_reg ? -x_inc : x_inc;
        step_y     = y_neg_reg ? -y_inc : y_inc;
        pos_x_next = pos_x_reg + $signed(step_x);
        pos_y_next = pos_y_reg + $signed(step_y);
        steps_dec  = steps_left_reg - 1'b1;
        px_step    = to_pixel(pos_x_next);
        py_step    = to_pixel(pos_y_next);
    end

    // Restoring divider: one quotient bit per cycle, divisor is the major length
    always_comb
    begin
        div_ge  = rem_reg >= {1'b0, steps_left_reg};
        rem_sub = div_ge ? (rem_reg - {1'b0, steps_left_reg}) : rem_reg;
    end

    assign status.div_last = (cnt_reg == '0);

    // Result selection
    always_comb
    begin
        o_x     = '0;
        o_y     = '0;
        o_val   = '0;
        o_valid = 1'b0;
        o_last  = 1'b0;
        o_idle  = 1'b1;
        if (ctrl.load_line)
        begin
            o_x     = start_x;
            o_y     = start_y;
            o_val   = pixel_value;
            o_valid = 1'b1;
            o_last  = !st_active;
            o_idle  = !st_active;
        end
        else if (active_reg)
        begin
            o_val   = line_value_reg;
            o_valid = 1'b1;
            if (steps_dec == '0)
            begin
                o_x    = target_x_reg;
                o_y    = target_y_reg;
                o_last = 1'b1;
            end
            else
            begin
                o_x    = px_step;
                o_y    = py_step;
                o_idle = 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= dda_pkg::ROWS_RESET;
            cols_reg <= dda_pkg::COLS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dda_pkg::REG_ROWS: rows_reg <= cfg_data;
                dda_pkg::REG_COLS: cols_reg <= cfg_data;
                default:           rows_reg <= rows_reg;
            endcase
        end
    end

    // Line activity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (ctrl.load_line)
        begin
            active_reg <= st_active;
        end
        else if (ctrl.advance && active_reg && (steps_dec == '0))
        begin
            active_reg <= 1'b0;
        end
    end

    // Line state and divider
    always_ff @(posedge clk)
    begin
        if (ctrl.load_line)
        begin
            pos_x_reg      <= {start_x, F'(0)};
            pos_y_reg      <= {start_y, F'(0)};
            target_x_reg   <= end_x;
            target_y_reg   <= end_y;
            steps_left_reg <= major;
            line_value_reg <= pixel_value;
            x_major_reg    <= st_x_major;
            x_neg_reg      <= dx[C];
            y_neg_reg      <= dy[C];
            rem_reg        <= {1'b0, minor};
            quo_reg        <= '0;
            cnt_reg        <= CNT_TOP;
        end
        else if (ctrl.div_run)
        begin
            quo_reg <= {quo_reg[F-1:0], div_ge};
            rem_reg <= {rem_sub[C-1:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
        else if (ctrl.advance && active_reg)
        begin
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            steps_left_reg <= steps_dec;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            pix_x_reg <= o_x;
            pix_y_reg <= o_y;
            value_reg <= o_val;
            we_reg    <= o_valid && in_image(o_x, o_y, rows_reg, cols_reg);
            last_reg  <= o_last;
            idle_reg  <= o_idle;
        end
    end

    assign pix_x         = pix_x_reg;
    assign pix_y         = pix_y_reg;
    assign pix_out_value = value_reg;
    assign write_enable  = we_reg;
    assign last          = last_reg;
    assign idle          = idle_reg;

endmodule

### hdl/dda_line_rasterizer.sv
// DDA line rasterizer with clipping: top level joining controller and datapath.
// A start transaction (action 0) loads two endpoints and a pixel value and returns
// the first pixel at once; it then stalls further input while a restoring divider
// forms the minor-axis increment one quotient bit per cycle. Each step transaction
// (action 1) returns the next pixel; after |major delta| steps the exact endpoint
// comes back flagged last. A step with no line in progress returns an all-zero
// pixel with idle set. Writes are enabled only for 0 <= x < cols and
// 0 <= y < rows. Results sit in an output register, so a new transaction is
// taken while the previous result is being handed off.
module dda_line_rasterizer #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dda_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [dda_pkg::DIM_BITS-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic signed [COORD_BITS-1:0]      start_x,
    input  logic signed [COORD_BITS-1:0]      start_y,
    input  logic signed [COORD_BITS-1:0]      end_x,
    input  logic signed [COORD_BITS-1:0]      end_y,
    input  logic [7:0]                        pixel_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [COORD_BITS-1:0]      pix_x,
    output logic signed [COORD_BITS-1:0]      pix_y,
    output logic [7:0]                        pix_out_value,
    output logic                              write_enable,
    output logic                              last,
    output logic                              idle
);

    dda_pkg::ctrl_t   ctrl;
    dda_pkg::status_t status;

    dda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    dda_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .pixel_value   (pixel_value),
        .pix_x         (pix_x),
        .pix_y         (pix_y),
        .pix_out_value (pix_out_value),
        .write_enable  (write_enable),
        .last          (last),
        .idle          (idle)
    );

endmodule

### dv/dda_line_checker.sv
// Checker for the DDA line rasterizer: tracks line state, predicts and compares each pixel.
module dda_line_checker #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dda_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [dda_pkg::DIM_BITS-1:0]      cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              action,
    input  logic signed [COORD_BITS-1:0]      start_x,
    input  logic signed [COORD_BITS-1:0]      start_y,
    input  logic signed [COORD_BITS-1:0]      end_x,
    input  logic signed [COORD_BITS-1:0]      end_y,
    input  logic [7:0]                        pixel_value,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [COORD_BITS-1:0]      pix_x,
    input  logic signed [COORD_BITS-1:0]      pix_y,
    input  logic [7:0]                        pix_out_value,
    input  logic                              write_enable,
    input  logic                              last,
    input  logic                              idle,
    output int                                mismatches,
    output int                                pending
);

    localparam int     POS_BITS  = COORD_BITS + FRAC_BITS;
    localparam int     STEP_BITS = FRAC_BITS + 2;
    localparam longint ONE       = longint'(1) << FRAC_BITS;
    localparam longint HALF      = longint'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [7:0]                   value;
        logic                         we;
        logic                         last;
        logic                         idle;
    } pixel_t;

    // image size registers as seen on the config port
    logic [dda_pkg::DIM_BITS-1:0] img_rows;
    logic [dda_pkg::DIM_BITS-1:0] img_cols;

    // line walker state
    logic                         line_active;
    logic signed [POS_BITS-1:0]   pos_x;
    logic signed [POS_BITS-1:0]   pos_y;
    logic signed [STEP_BITS-1:0]  inc_x;
    logic signed [STEP_BITS-1:0]  inc_y;
    logic signed [COORD_BITS-1:0] goal_x;
    logic signed [COORD_BITS-1:0] goal_y;
    logic [12:0]                  steps_to_go;
    logic [7:0]                   line_value;

    pixel_t                       pending_pixels[$];
    pixel_t                       want;

    // clip test against the configured image
    function automatic logic in_image(logic signed [COORD_BITS-1:0] x,
                                      logic signed [COORD_BITS-1:0] y);
        return x >= 0 && y >= 0 && int'(x) < int'(img_cols) && int'(y) < int'(img_rows);
    endfunction

    // round half up, then truncate toward zero
    function automatic logic signed [COORD_BITS-1:0] to_pixel(logic signed [POS_BITS-1:0] p);
        longint v;
        v = (longint'(p) + HALF) / ONE;
        return v[COORD_BITS-1:0];
    endfunction

    // minor axis increment: magnitude truncated, sign of the delta
    function automatic logic signed [STEP_BITS-1:0] minor_inc(longint minor, longint major);
        longint q;
        q = ((minor < 0 ? -minor : minor) * ONE) / major;
        return STEP_BITS'(minor < 0 ? -q : q);
    endfunction

    // advance the line state by one transaction and return the pixel it yields
    function automatic pixel_t trace_pixel(logic act,
                                           logic signed [COORD_BITS-1:0] x1,
                                           logic signed [COORD_BITS-1:0] y1,
                                           logic signed [COORD_BITS-1:0] x2,
                                           logic signed [COORD_BITS-1:0] y2,
                                           logic [7:0] value);
        longint dx, dy, ax, ay, major;
        pixel_t px;
        px = '0;
        if (act == dda_pkg::ACT_START)
        begin
            dx = longint'(x2) - longint'(x1);
            dy = longint'(y2) - longint'(y1);
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            line_value = value;
            goal_x = x2;
            goal_y = y2;
            pos_x = POS_BITS'(longint'(x1) * ONE);
            pos_y = POS_BITS'(longint'(y1) * ONE);
            if (ax > ay)
            begin
                major = ax;
                inc_x = STEP_BITS'(dx < 0 ? -ONE : ONE);
                inc_y = minor_inc(dy, ax);
            end
            else if (ay > 0)
            begin
                // ties go to the y axis
                major = ay;
                inc_y = STEP_BITS'(dy < 0 ? -ONE : ONE);
                inc_x = minor_inc(dx, ay);
            end
            else
            begin
                major = 0;
                inc_x = '0;
                inc_y = '0;
            end
            steps_to_go = major[12:0];
            line_active = major != 0;
            px.x = x1;
            px.y = y1;
            px.value = value;
            px.we = in_image(x1, y1);
            px.last = !line_active;
            px.idle = !line_active;
        end
        else if (!line_active)
        begin
            // step with no line: blank pixel, idle
            px.idle = 1'b1;
        end
        else
        begin
            steps_to_go = steps_to_go - 13'd1;
            pos_x = pos_x + inc_x;
            pos_y = pos_y + inc_y;
            px.value = line_value;
            if (steps_to_go == 0)
            begin
                // final step lands exactly on the endpoint
                line_active = 1'b0;
                px.x = goal_x;
                px.y = goal_y;
                px.last = 1'b1;
                px.idle = 1'b1;
            end
            else
            begin
                px.x = to_pixel(pos_x);
                px.y = to_pixel(pos_y);
            end
            px.we = in_image(px.x, px.y);
        end
        return px;
    endfunction

    function automatic void check_field(string field, logic signed [31:0] expected,
                                        logic signed [31:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected %0d, got %0d", field, expected, actual);
            mismatches++;
        end
    endfunction

    // watch config, output and input channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_rows = dda_pkg::ROWS_RESET;
            img_cols = dda_pkg::COLS_RESET;
            line_active = 1'b0;
            pos_x = '0;
            pos_y = '0;
            inc_x = '0;
            inc_y = '0;
            goal_x = '0;
            goal_y = '0;
            steps_to_go = '0;
            line_value = '0;
            pending_pixels.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == dda_pkg::REG_ROWS)
                    img_rows = cfg_data;
                else if (cfg_index == dda_pkg::REG_COLS)
                    img_cols = cfg_data;
            end

            if (out_valid && !out_stall)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("pixel transaction with no expectation pending");
                    mismatches++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    check_field("pix_x", want.x, pix_x);
                    check_field("pix_y", want.y, pix_y);
                    check_field("pix_out_value", want.value, pix_out_value);
                    check_field("write_enable", want.we, write_enable);
                    check_field("last", want.last, last);
                    check_field("idle", want.idle, idle);
                end
            end

            if (in_valid && !in_stall)
                pending_pixels.push_back(trace_pixel(action, start_x, start_y,
                                                     end_x, end_y, pixel_value));

            pending = pending_pixels.size();
        end
    end

endmodule

### dv/dda_line_rasterizer_tb.sv
// Testbench top for the DDA line rasterizer: clock, reset, stimulus and verdict.
module dda_line_rasterizer_tb;

    localparam int COORD_BITS    = 12;
    localparam int FRAC_BITS     = 16;
    localparam int DIM_BITS      = dda_pkg::DIM_BITS;
    localparam int CMAX          = (1 << (COORD_BITS - 1)) - 1;
    localparam int CMIN          = -(1 << (COORD_BITS - 1));
    localparam int SETTLE_CYCLES = FRAC_BITS + 24;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 145;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [dda_pkg::CFG_IDX_BITS-1:0] cfg_index = dda_pkg::REG_ROWS;
    logic [DIM_BITS-1:0]              cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic                             action = dda_pkg::ACT_STEP;
    logic signed [COORD_BITS-1:0]     start_x = '0;
    logic signed [COORD_BITS-1:0]     start_y = '0;
    logic signed [COORD_BITS-1:0]     end_x = '0;
    logic signed [COORD_BITS-1:0]     end_y = '0;
    logic [7:0]                       pixel_value = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic signed [COORD_BITS-1:0]     pix_x;
    logic signed [COORD_BITS-1:0]     pix_y;
    logic [7:0]                       pix_out_value;
    logic                             write_enable;
    logic                             last;
    logic                             idle;

    int                               mismatches;
    int                               pending;
    int                               items_sent = 0;
    logic                             calm = 1'b0;
    logic [DIM_BITS-1:0]              img_rows = dda_pkg::ROWS_RESET;
    logic [DIM_BITS-1:0]              img_cols = dda_pkg::COLS_RESET;

    dda_line_rasterizer #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .pixel_value   (pixel_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pix_x         (pix_x),
        .pix_y         (pix_y),
        .pix_out_value (pix_out_value),
        .write_enable  (write_enable),
        .last          (last),
        .idle          (idle)
    );

    dda_line_checker #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .pixel_value   (pixel_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pix_x         (pix_x),
        .pix_y         (pix_y),
        .pix_out_value (pix_out_value),
        .write_enable  (write_enable),
        .last          (last),
        .idle          (idle),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // 8 time unit clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    // receiver: random stall ahead of each pixel transaction
    initial
    begin
        int hold;
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 3);
            if (hold != 0)
            begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!(rst_n && out_valid));
            @(negedge clk);
        end
    end

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(int v);
        if (v > CMAX)
            return CMAX[COORD_BITS-1:0];
        if (v < CMIN)
            return CMIN[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    // present one transaction after a random gap; returns at the negedge after acceptance
    task automatic send_item(logic act,
                             logic signed [COORD_BITS-1:0] x1,
                             logic signed [COORD_BITS-1:0] y1,
                             logic signed [COORD_BITS-1:0] x2,
                             logic signed [COORD_BITS-1:0] y2,
                             logic [7:0] value);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action = act;
        start_x = x1;
        start_y = y1;
        end_x = x2;
        end_y = y2;
        pixel_value = value;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    // step with junk on the unused fields
    task automatic send_step();
        send_item(dda_pkg::ACT_STEP, COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                  COORD_BITS'($urandom()), COORD_BITS'($urandom()), 8'($urandom()));
    endtask

    task automatic send_line(int x1, int y1, int x2, int y2, int value, int steps);
        send_item(dda_pkg::ACT_START, x1[COORD_BITS-1:0], y1[COORD_BITS-1:0],
                  x2[COORD_BITS-1:0], y2[COORD_BITS-1:0], value[7:0]);
        repeat (steps) send_step();
    endtask

    // drain all pixels, then give the divider time to finish
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_image(logic [DIM_BITS-1:0] rows_v, logic [DIM_BITS-1:0] cols_v);
        cfg_we = 1'b1;
        cfg_index = dda_pkg::REG_ROWS;
        cfg_data = rows_v;
        @(negedge clk);
        cfg_index = dda_pkg::REG_COLS;
        cfg_data = cols_v;
        @(negedge clk);
        cfg_we = 1'b0;
        img_rows = rows_v;
        img_cols = cols_v;
    endtask

    // one random line, mostly walked to its end; sometimes cut short or overrun, or just a lone step
    task automatic run_line();
        logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
        int pick, dx, dy, major, steps;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            send_step();
            return;
        end

        // first endpoint: anywhere, near the far image edge, near the origin, inside
        case ($urandom_range(0, 3))
            0:
            begin
                x1 = COORD_BITS'($urandom());
                y1 = COORD_BITS'($urandom());
            end
            1:
            begin
                x1 = clamp_coord(int'(img_cols) - 3 + int'($urandom_range(0, 6)));
                y1 = clamp_coord(int'(img_rows) - 3 + int'($urandom_range(0, 6)));
            end
            2:
            begin
                x1 = clamp_coord(int'($urandom_range(0, 8)) - 4);
                y1 = clamp_coord(int'($urandom_range(0, 8)) - 4);
            end
            default:
            begin
                x1 = clamp_coord(int'($urandom_range(0, img_cols)));
                y1 = clamp_coord(int'($urandom_range(0, img_rows)));
            end
        endcase

        // second endpoint: mostly short lines
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            x2 = COORD_BITS'($urandom());
            y2 = COORD_BITS'($urandom());
        end
        else if (pick < 14)
        begin
            x2 = clamp_coord(int'(x1) + int'($urandom_range(0, 400)) - 200);
            y2 = clamp_coord(int'(y1) + int'($urandom_range(0, 400)) - 200);
        end
        else
        begin
            x2 = clamp_coord(int'(x1) + int'($urandom_range(0, 24)) - 12);
            y2 = clamp_coord(int'(y1) + int'($urandom_range(0, 24)) - 12);
        end

        send_item(dda_pkg::ACT_START, x1, y1, x2, y2, 8'($urandom_range(0, 255)));

        dx = int'(x2) - int'(x1);
        dy = int'(y2) - int'(y1);
        dx = dx < 0 ? -dx : dx;
        dy = dy < 0 ? -dy : dy;
        major = dx > dy ? dx : dy;
        steps = major;
        if (major > 400)
            steps = $urandom_range(0, 40);
        else if (major > 0 && $urandom_range(0, 9) == 0)
            steps = $urandom_range(0, major - 1);
        repeat (steps) send_step();
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 2)) send_step();
    endtask

    task automatic random_phase();
        int target;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            run_line();
        end
        calm = 1'b0;
    endtask

    // main stimulus
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle step, degenerate lines at both corners, axis lines,
        // a tie on the diagonal, an extreme line abandoned by a new start,
        // a line with negative direction and a step past its end
        send_step();
        send_line(CMAX, CMAX, CMAX, CMAX, 255, 0);
        send_line(CMIN, CMIN, CMIN, CMIN, 0, 0);
        send_line(0, 0, 3, 0, 'hA5, 3);
        send_line(0, 0, 0, -2, 'h5A, 2);
        send_line(5, 5, 2, 2, 'h3C, 3);
        send_line(CMIN, CMAX, CMAX, CMIN, 'hC3, 2);
        send_line(10, 1, 4, 5, 'h81, 6);
        send_step();

        random_phase();

        // later phases change the image size between runs
        for (int p = 1; p < PHASES; p++)
        begin
            settle();
            case (p)
                1: apply_image(12'd1, 12'd1);
                2: apply_image(12'd4095, 12'd4095);
                3: apply_image(12'd0, 12'd2047);
                4: apply_image(12'd2047, 12'd0);
                default: apply_image(DIM_BITS'($urandom_range(1, 1024)),
                                     DIM_BITS'($urandom_range(1, 1024)));
            endcase
            random_phase();
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
hdl/dda_pkg.sv
hdl/dda_ctrl.sv
hdl/dda_datapath.sv
hdl/dda_line_rasterizer.sv
dv/dda_line_checker.sv
dv/dda_line_rasterizer_tb.sv
